[design/crgb_pkg.sv]
// ----------------------------------------------------------------------------
// crgb_pkg
// Shared types, constants and helpers for the chainable RGB LED frame driver.
// ----------------------------------------------------------------------------
package crgb_pkg;

   // field widths
   localparam int CNT_W   = 6;
   localparam int COLOR_W = 24;
   localparam int WORD_W  = 32;

   // default number of LEDs the color store holds
   localparam int MAX_LEDS_DEFAULT = 32;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);

   // request codes on the input channel
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_REFRESH = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // flag byte base of every LED word
   localparam logic [7:0] FLAG_BASE = 8'hC0;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [CNT_W-1:0] led_index;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_word;
      logic              last_word;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_REFRESH,
      CMD_CLEAR
   } cmd_kind_type;

   // one classified command in the queue
   typedef struct packed {
      cmd_kind_type       kind;
      logic [CNT_W-1:0]   index;
      logic [COLOR_W-1:0] color;   // blue, green, red from the top down
      logic [CNT_W-1:0]   count;   // LEDs driven, already limited
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_BODY,
      ST_TAIL
   } back_state_type;

   // LED word: flag, blue, green, red; flag carries inverted top bits
   function automatic logic [WORD_W-1:0] led_word(input logic [COLOR_W-1:0] color);
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic [7:0] flag;
      b    = color[23:16];
      g    = color[15:8];
      r    = color[7:0];
      flag = FLAG_BASE | {2'b00, ~b[7:6], ~g[7:6], ~r[7:6]};
      return {flag, b, g, r};
   endfunction

endpackage

[design/crgb_front.sv]
// ----------------------------------------------------------------------------
// crgb_front
// Takes requests, holds the LED count register and turns each request into a
// queue command; requests that do nothing are dropped here.
// ----------------------------------------------------------------------------
module crgb_front import crgb_pkg::*; #(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_item_type     req_payload,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  fifo_status_type  q_stat,
   output logic             busy,
   output logic             q_push,
   output cmd_type          q_entry
);

   logic [CNT_W-1:0] led_count_ff;
   logic [CNT_W-1:0] eff_count;
   logic             accept;

   // led count register
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= CNT_W'(1);
      end else if (csr_wr_en) begin
         led_count_ff <= csr_wr_data;
      end
   end

   // count above the store size acts as the store size
   assign eff_count = (led_count_ff > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_ff;

   assign busy   = q_stat.full;
   assign accept = start && !q_stat.full;

   // classify the request
   always_comb begin
      q_push        = 1'b0;
      q_entry.kind  = CMD_WRITE;
      q_entry.index = req_payload.led_index;
      q_entry.color = {req_payload.blue, req_payload.green, req_payload.red};
      q_entry.count = eff_count;
      case (req_payload.req_type)
         REQ_WRITE: begin
            q_entry.kind = CMD_WRITE;
            q_push = accept && (req_payload.led_index != '0)
                     && (req_payload.led_index <= eff_count);
         end
         REQ_REFRESH: begin
            q_entry.kind = CMD_REFRESH;
            q_push       = accept;
         end
         REQ_CLEAR: begin
            q_entry.kind = CMD_CLEAR;
            q_push       = accept;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

endmodule

[design/crgb_fifo.sv]
// ----------------------------------------------------------------------------
// crgb_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module crgb_fifo import crgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         wr_entry,
   input  logic            pop,
   output cmd_type         rd_entry,
   output fifo_status_type stat
);

   cmd_type          entries_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW:0]     cnt_ff;
   logic [QAW-1:0]   wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_in;
   logic [QAW:0]     cnt_in;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_entry   = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH-1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH-1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + (QAW+1)'(1);
         2'b01:   cnt_in = cnt_ff - (QAW+1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

[design/crgb_back.sv]
// ----------------------------------------------------------------------------
// crgb_back
// Executes queued commands: color store writes, store clears and frame
// emission, reading the store one LED per cycle.
// ----------------------------------------------------------------------------
module crgb_back import crgb_pkg::*; #(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      q_head,
   input  logic         q_empty,
   output logic         q_pop,
   output logic         rsp_strobe,
   output rsp_item_type rsp_payload
);

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   logic [COLOR_W-1:0] mem [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   back_state_type     state_ff;
   back_state_type     state_in;
   logic [AW-1:0]      idx_ff;
   logic [AW-1:0]      idx_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               mem_we;
   logic               clear_all;
   logic               last_led;

   assign last_led = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign wr_addr  = AW'(q_head.index - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && (q_head.kind != CMD_WRITE)) begin
               state_in = ST_HEAD;
               cnt_in   = q_head.count;
            end
         end
         ST_HEAD: begin
            idx_in   = '0;
            state_in = (cnt_ff == '0) ? ST_TAIL : ST_BODY;
         end
         ST_BODY: begin
            if (last_led) begin
               state_in = ST_TAIL;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_TAIL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and store control
   always_comb begin
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      clear_all   = 1'b0;
      rd_addr     = '0;
      rsp_strobe  = 1'b0;
      rsp_payload = '0;
      case (state_ff)
         ST_IDLE: begin
            q_pop     = !q_empty;
            mem_we    = !q_empty && (q_head.kind == CMD_WRITE);
            clear_all = !q_empty && (q_head.kind == CMD_CLEAR);
         end
         ST_HEAD: begin
            rsp_strobe = 1'b1;
            rd_addr    = '0;
         end
         ST_BODY: begin
            rsp_strobe             = 1'b1;
            rsp_payload.frame_word = led_word(rd_valid_ff ? rd_data_ff : '0);
            rd_addr                = last_led ? idx_ff : idx_ff + AW'(1);
         end
         ST_TAIL: begin
            rsp_strobe            = 1'b1;
            rsp_payload.last_word = 1'b1;
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         if (clear_all) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // color store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= q_head.color;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

endmodule

[design/chainable_rgb_led_frame_driver.sv]
// ----------------------------------------------------------------------------
// chainable_rgb_led_frame_driver
// Color store and frame word generator for a chain of two-wire RGB LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer happens on a clock edge with start high and busy low.
//   Type write stores one LED color at a 1-based index; type refresh emits a
//   frame; type clear zeroes the store and then emits a frame. Writes to
//   index zero or beyond the LED count, and the unused code, are dropped.
//   Each frame word leaves on rsp_payload for one cycle with rsp_strobe high;
//   the receiver cannot stall, so words go out back to back: a zero start
//   word, one word per LED (flag, blue, green, red), a zero end word marked
//   by last_word. Each word is meant to be shifted out MSB first.
//   A two-entry command queue parts intake from execution: busy rises only
//   when it is full. The back end pops a write and stores it in the same
//   cycle; a refresh runs pop, start word, one word per LED, end word, the
//   start word following in the cycle after the back end pops the command.
//   The store reads one entry per cycle, which sets the refresh length.
//   csr_wr_en writes the LED count (reset value 1); write it only while idle.
//   Reset empties the queue, returns the back end to idle and clears every
//   store entry at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module chainable_rgb_led_frame_driver import crgb_pkg::*; #(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_payload,
   output logic             rsp_strobe,
   output rsp_item_type     rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   fifo_status_type q_stat;
   logic            q_push;
   logic            q_pop;
   cmd_type         q_entry;
   cmd_type         q_head;

   // request intake and classification
   crgb_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_stat      (q_stat),
      .busy        (busy),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // command queue
   crgb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_entry),
      .pop      (q_pop),
      .rd_entry (q_head),
      .stat     (q_stat)
   );

   // store and frame emission
   crgb_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_empty     (q_stat.empty),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   // a frame ends with a gap before the next frame starts
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_word) |=> !rsp_strobe)
      else $error("frame word right after end word");

   // popping a refresh or clear command starts a frame with the zero start word
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_head.kind != CMD_WRITE)) |=>
         (rsp_strobe && (rsp_payload.frame_word == '0) && !rsp_payload.last_word))
      else $error("refresh did not open with a start word");

   // the queue never takes a command while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full command queue");
`endif

endmodule
